// ===== rtl/core/lced_pkg.sv =====
// Shared types and constants for the loudness event detector.
`timescale 1ns / 1ps

package lced_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_WINDOW_ROUNDS    = 3'd0;
    localparam logic [2:0] REG_LOUD_THRESHOLD   = 3'd1;
    localparam logic [2:0] REG_COOLDOWN_WINDOWS = 3'd2;
    localparam logic [2:0] REG_PERIODIC_WINDOWS = 3'd3;
    localparam logic [2:0] REG_WINDOW_MS        = 3'd4;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    // Configuration reset values
    localparam logic [15:0] RST_WINDOW_ROUNDS    = 16'd3000;
    localparam logic [11:0] RST_LOUD_THRESHOLD   = 12'd3000;
    localparam logic [7:0]  RST_COOLDOWN_WINDOWS = 8'd15;
    localparam logic [7:0]  RST_PERIODIC_WINDOWS = 8'd50;
    localparam logic [15:0] RST_WINDOW_MS        = 16'd300;

    localparam logic [15:0] FIRST_EVENT_NUMBER = 16'd1000;
    localparam logic [7:0]  WINDOW_COUNT_MAX   = 8'd255;
    localparam logic [6:0]  PCT_SCALE          = 7'd100;

    // Window queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic [15:0] window_rounds;
        logic [11:0] loud_threshold;
        logic [7:0]  cooldown_windows;
        logic [7:0]  periodic_windows;
        logic [15:0] window_ms;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== rtl/core/three_channel_loudness_event_detector.sv =====
// Top level of the three-channel loudness event detector.
`timescale 1ns / 1ps

// Takes one round of microphone samples per transaction and tracks each
// channel's minimum and maximum across a window of window_rounds rounds. The
// round that closes a window produces one result transaction: the largest
// peak-to-peak span, the channel it came from (ties go to the lower
// channel), intensity as span*100/full-scale, a high alert (span above
// loud_threshold with the cooldown expired; it reloads the cooldown), a
// periodic flag after periodic_windows windows without an event, the event
// number (0 when neither fires, numbering from 1000) and the running time.
// Rate: one input transaction per clock; the front end only stalls when the
// four-entry window queue is full, which takes output back-pressure.
// A window result goes through the queue, stage A, stage B and the result
// register; the back end is a three-stage pipeline that advances whenever
// its result register is empty or being taken. The user writes the
// configuration through cfg_we/cfg_index/cfg_data only while idle; the
// block does not enforce this. Writes to unknown indexes are dropped.

module three_channel_loudness_event_detector
    import lced_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int CHANNELS    = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // sample per channel from the lowest bit: sample_left, sample_front,
    // sample_right (SAMPLE_BITS each), zero padded to bytes
    input  logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // from the lowest bit: peak_level, direction, intensity (7),
    // high_alert, periodic_event, event_number (16), time_ms (32),
    // cooldown_left (8), zero padded to bytes
    output logic [((SAMPLE_BITS+((CHANNELS>4)?3:2)+65+7)/8)*8-1:0] m_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int DIR_BITS = (CHANNELS > 4) ? 3 : 2;
    localparam int IN_W     = CHANNELS * SAMPLE_BITS;
    localparam int OUT_BITS = ((SAMPLE_BITS + DIR_BITS + 65 + 7) / 8) * 8;

    cfg_t              cfg_reg;
    queue_status_t     q_status;
    logic              push;
    logic              pop;
    logic [IN_W-1:0]   push_span;
    logic [IN_W-1:0]   pop_span;

    // Hold configuration; ignore writes beyond the register list.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_rounds    <= RST_WINDOW_ROUNDS;
            cfg_reg.loud_threshold   <= RST_LOUD_THRESHOLD;
            cfg_reg.cooldown_windows <= RST_COOLDOWN_WINDOWS;
            cfg_reg.periodic_windows <= RST_PERIODIC_WINDOWS;
            cfg_reg.window_ms        <= RST_WINDOW_MS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW_ROUNDS:    cfg_reg.window_rounds    <= cfg_data;
                REG_LOUD_THRESHOLD:   cfg_reg.loud_threshold   <= cfg_data[11:0];
                REG_COOLDOWN_WINDOWS: cfg_reg.cooldown_windows <= cfg_data[7:0];
                REG_PERIODIC_WINDOWS: cfg_reg.periodic_windows <= cfg_data[7:0];
                REG_WINDOW_MS:        cfg_reg.window_ms        <= cfg_data;
                default:              ;
            endcase
        end
    end

    lced_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CHANNELS    (CHANNELS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .samples       (s_tdata[IN_W-1:0]),
        .window_rounds (cfg_reg.window_rounds),
        .q_status      (q_status),
        .push          (push),
        .span_vec      (push_span)
    );

    lced_queue #(
        .WIDTH (IN_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_span),
        .pop       (pop),
        .pop_data  (pop_span),
        .status    (q_status)
    );

    lced_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CHANNELS    (CHANNELS),
        .DIR_BITS    (DIR_BITS),
        .OUT_BITS    (OUT_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_status (q_status),
        .span_vec (pop_span),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== rtl/core/lced_front.sv =====
// Front end: sample acceptance, per-channel min/max tracking and window closing.
`timescale 1ns / 1ps

module lced_front
    import lced_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int CHANNELS    = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [CHANNELS*SAMPLE_BITS-1:0] samples,
    input  logic [15:0]                   window_rounds,
    input  queue_status_t                 q_status,
    output logic                          push,
    output logic [CHANNELS*SAMPLE_BITS-1:0] span_vec
);

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

    logic [SAMPLE_BITS-1:0] max_reg [CHANNELS];
    logic [SAMPLE_BITS-1:0] min_reg [CHANNELS];
    logic [SAMPLE_BITS-1:0] max_next [CHANNELS];
    logic [SAMPLE_BITS-1:0] min_next [CHANNELS];
    logic [15:0]            round_reg;
    logic [15:0]            round_next;
    logic [15:0]            limit;
    logic                   window_end;
    logic                   accept;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            max_next[c] = (samples[c*SAMPLE_BITS +: SAMPLE_BITS] > max_reg[c])
                          ? samples[c*SAMPLE_BITS +: SAMPLE_BITS] : max_reg[c];
            min_next[c] = (samples[c*SAMPLE_BITS +: SAMPLE_BITS] < min_reg[c])
                          ? samples[c*SAMPLE_BITS +: SAMPLE_BITS] : min_reg[c];
            span_vec[c*SAMPLE_BITS +: SAMPLE_BITS] = max_next[c] - min_next[c];
        end
    end

    // A zero window length acts as one round; a shortened length closes at once.
    assign limit      = (window_rounds == 16'd0) ? 16'd1 : window_rounds;
    assign round_next = round_reg + 16'd1;
    assign window_end = (round_next == 16'd0) || (round_next >= limit);
    assign push       = accept && window_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_reg <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                max_reg[c] <= '0;
                min_reg[c] <= SAMPLE_MAX;
            end
        end
        else if (accept)
        begin
            if (window_end)
            begin
                round_reg <= '0;
                for (int c = 0; c < CHANNELS; c++)
                begin
                    max_reg[c] <= '0;
                    min_reg[c] <= SAMPLE_MAX;
                end
            end
            else
            begin
                round_reg <= round_next;
                for (int c = 0; c < CHANNELS; c++)
                begin
                    max_reg[c] <= max_next[c];
                    min_reg[c] <= min_next[c];
                end
            end
        end
    end

endmodule

// ===== rtl/core/lced_queue.sv =====
// Short queue of closed-window spans between front and back.
`timescale 1ns / 1ps

module lced_queue
    import lced_pkg::*;
#(
    parameter int WIDTH = 36
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output queue_status_t    status
);

    logic [WIDTH-1:0]    mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign status.full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_data     = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/lced_back.sv =====
// Back end: loudest channel, event decisions, intensity and result register.
`timescale 1ns / 1ps

module lced_back
    import lced_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int CHANNELS    = 3,
    parameter int DIR_BITS    = 2,
    parameter int OUT_BITS    = 80
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  cfg_t                            cfg,
    input  queue_status_t                   q_status,
    input  logic [CHANNELS*SAMPLE_BITS-1:0] span_vec,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [OUT_BITS-1:0]             m_tdata
);

    localparam int XW = SAMPLE_BITS + 7;
    localparam int QW = 8;
    localparam logic [XW:0] SAMPLE_MAX_X = (XW+1)'((1 << SAMPLE_BITS) - 1);

    logic advance;

    // Stage A: loudest channel
    logic                   valid_a_reg;
    logic [SAMPLE_BITS-1:0] peak_a_reg;
    logic [DIR_BITS-1:0]    dir_a_reg;
    logic [SAMPLE_BITS-1:0] peak_sel;
    logic [DIR_BITS-1:0]    dir_sel;

    // Stage B: event decisions and scaled peak
    logic                   valid_b_reg;
    logic [SAMPLE_BITS-1:0] peak_b_reg;
    logic [DIR_BITS-1:0]    dir_b_reg;
    logic [XW-1:0]          prod_b_reg;
    logic                   high_b_reg;
    logic                   periodic_b_reg;
    logic [15:0]            evnum_b_reg;
    logic [31:0]            time_b_reg;
    logic [7:0]             cool_b_reg;

    // Running event state
    logic [7:0]  cooldown_reg;
    logic [7:0]  wse_reg;
    logic [15:0] next_ev_reg;
    logic [31:0] elapsed_reg;
    logic [7:0]  cd_dec;
    logic [7:0]  wse_inc;
    logic [31:0] elapsed_next;
    logic        high;
    logic        periodic;
    logic        trigger;

    // Stage C: divide by full scale, result register
    logic [XW:0]  x_ext;
    logic [XW:0]  q_sum;
    logic [QW-1:0] q0;
    logic [XW:0]  q_times_max;
    logic [XW:0]  rem;
    logic [6:0]   pct;
    logic         out_valid_reg;
    logic [OUT_BITS-1:0] out_data_reg;

    // The whole back pipeline moves together whenever the result slot frees.
    assign advance = !out_valid_reg || m_tready;
    assign pop     = advance && !q_status.empty;

    always_comb
    begin
        peak_sel = span_vec[SAMPLE_BITS-1:0];
        dir_sel  = '0;
        for (int c = 1; c < CHANNELS; c++)
        begin
            if (span_vec[c*SAMPLE_BITS +: SAMPLE_BITS] > peak_sel)
            begin
                peak_sel = span_vec[c*SAMPLE_BITS +: SAMPLE_BITS];
                dir_sel  = DIR_BITS'(c);
            end
        end
    end

    always_comb
    begin
        cd_dec       = (cooldown_reg != 8'd0) ? cooldown_reg - 8'd1 : 8'd0;
        wse_inc      = (wse_reg != WINDOW_COUNT_MAX) ? wse_reg + 8'd1 : WINDOW_COUNT_MAX;
        elapsed_next = elapsed_reg + 32'(cfg.window_ms);
        high         = (17'(peak_a_reg) > 17'(cfg.loud_threshold)) && (cd_dec == 8'd0);
        periodic     = (wse_inc >= cfg.periodic_windows);
        trigger      = high || periodic;
    end

    // Quotient by 2^n - 1: estimate, then one correction step.
    always_comb
    begin
        x_ext       = (XW+1)'(prod_b_reg);
        q_sum       = x_ext + (x_ext >> SAMPLE_BITS);
        q0          = QW'(q_sum >> SAMPLE_BITS);
        q_times_max = ((XW+1)'(q0) << SAMPLE_BITS) - (XW+1)'(q0);
        rem         = x_ext - q_times_max;
        pct         = 7'(q0) + ((rem >= SAMPLE_MAX_X) ? 7'd1 : 7'd0);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            peak_a_reg <= peak_sel;
            dir_a_reg  <= dir_sel;
            peak_b_reg <= peak_a_reg;
            dir_b_reg  <= dir_a_reg;
            prod_b_reg <= XW'(peak_a_reg) * XW'(PCT_SCALE);
            high_b_reg     <= high;
            periodic_b_reg <= periodic;
            evnum_b_reg    <= trigger ? next_ev_reg : 16'd0;
            time_b_reg     <= elapsed_next;
            cool_b_reg     <= high ? cfg.cooldown_windows : cd_dec;
            out_data_reg   <= OUT_BITS'({cool_b_reg, time_b_reg, evnum_b_reg,
                                         periodic_b_reg, high_b_reg, pct,
                                         dir_b_reg, peak_b_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg   <= 1'b0;
            valid_b_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            cooldown_reg  <= '0;
            wse_reg       <= '0;
            next_ev_reg   <= FIRST_EVENT_NUMBER;
            elapsed_reg   <= '0;
        end
        else if (advance)
        begin
            valid_a_reg   <= !q_status.empty;
            valid_b_reg   <= valid_a_reg;
            out_valid_reg <= valid_b_reg;
            if (valid_a_reg)
            begin
                cooldown_reg <= high ? cfg.cooldown_windows : cd_dec;
                wse_reg      <= trigger ? 8'd0 : wse_inc;
                next_ev_reg  <= next_ev_reg + (trigger ? 16'd1 : 16'd0);
                elapsed_reg  <= elapsed_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/core/lced_checker.sv =====
// Port-level checks on the loudness event detector, bound to the top level.
`timescale 1ns / 1ps

module lced_checker #(
    parameter int SAMPLE_BITS = 12,
    parameter int CHANNELS    = 3,
    parameter int OUT_BITS    = 80
) (
    input logic                clk,
    input logic                rst_n,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OUT_BITS-1:0] m_tdata
);

    localparam int DIR_BITS = (CHANNELS > 4) ? 3 : 2;
    localparam int PCT_LO   = SAMPLE_BITS + DIR_BITS;
    localparam int HIGH_BIT = PCT_LO + 7;
    localparam int PER_BIT  = HIGH_BIT + 1;
    localparam int EV_LO    = PER_BIT + 1;

    // Hold a stalled result.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // No trigger means no event number.
    a_no_event: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[HIGH_BIT] && !m_tdata[PER_BIT]
            |-> m_tdata[EV_LO +: 16] == 16'd0)
        else $error("event number without a trigger");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[PCT_LO +: 7] <= 7'd100)
        else $error("intensity above 100");

    a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> 32'(m_tdata[SAMPLE_BITS +: DIR_BITS]) < CHANNELS)
        else $error("direction names no channel");

endmodule

bind three_channel_loudness_event_detector lced_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CHANNELS    (CHANNELS),
    .OUT_BITS    (OUT_BITS)
) u_lced_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sv/testbench.sv =====
// Self-checking stream testbench for the three-channel loudness event detector.
`timescale 1ns / 1ps

module testbench;
    import lced_pkg::*;

    localparam int SMP_W         = 12;
    localparam int NCH           = 3;
    localparam int IN_W          = 40;  // three samples, padded to bytes
    localparam int OUT_W         = 80;  // 79 result bits, padded to bytes
    localparam logic [11:0] FULL_SCALE = 12'hFFF;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;   // margin for the queue and back pipeline to empty
    localparam int OPEN_QUIET    = 5;   // quiet rounds sent under reset settings
    localparam int OPEN_TOTAL    = 22;

    // Opening rounds as {left, front, right}. The first five stay quiet under
    // the reset window length; the rest follow a mid-window shrink to 4 rounds:
    // one closing round, then a loud left window, an all-channel tie, a loud
    // front channel and a loud right channel.
    localparam int OPENING [0:OPEN_TOTAL-1][0:2] = '{
        '{2048, 2050, 2047}, '{2049, 2048, 2050}, '{2046, 2049, 2048},
        '{2050, 2047, 2049}, '{2048, 2048, 2048},
        '{2048, 2048, 2048},
        '{0, 100, 200}, '{4095, 110, 210}, '{2000, 120, 220}, '{1, 130, 230},
        '{0, 0, 0}, '{4095, 4095, 4095}, '{10, 10, 10}, '{20, 20, 20},
        '{4095, 0, 4095}, '{4095, 3000, 4095}, '{4095, 5, 4095}, '{4095, 6, 4095},
        '{100, 500, 0}, '{200, 900, 4095}, '{150, 700, 30}, '{120, 600, 40}
    };

    typedef struct {
        logic [11:0] peak;
        logic [1:0]  dir;
        logic [6:0]  pct;
        logic        alert;
        logic        periodic;
        logic [15:0] evnum;
        logic [31:0] ms;
        logic [7:0]  cool;
    } window_report_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [IN_W-1:0]                s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [OUT_W-1:0]               m_tdata;
    logic                           cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0]      cfg_index = REG_WINDOW_ROUNDS;
    logic [CFG_DATA_BITS-1:0]       cfg_data  = '0;

    // Tracker state: mirrors what the block holds between rounds
    cfg_t        live_cfg;
    logic [11:0] peak_hold [NCH];
    logic [11:0] trough_hold [NCH];
    logic [15:0] rounds_in;
    logic [7:0]  windows_idle;
    logic [7:0]  cooldown_now;
    logic [15:0] event_seq;
    logic [31:0] clock_ms;

    logic [NCH*SMP_W-1:0] round_q [$];   // rounds waiting to be sent
    window_report_t       window_q [$];  // window results still owed by the block

    int src_gap, src_rate, sink_gap, sink_rate;
    bit calm;
    int mismatches, stall_cycles;

    three_channel_loudness_event_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Restart the per-channel extremes at the start of every window.
    function automatic void open_window();
        for (int c = 0; c < NCH; c++)
        begin
            peak_hold[c]   = '0;
            trough_hold[c] = FULL_SCALE;
        end
        rounds_in = '0;
    endfunction

    // Fold one round into the tracker; returns 1 when the round closes a
    // window, with the window's result in rep.
    function automatic bit tally_round(input logic [NCH*SMP_W-1:0] samples,
                                       output window_report_t rep);
        logic [11:0] smp;
        logic [11:0] span;
        logic [11:0] peak;
        logic [15:0] needed;
        logic [1:0]  dir;
        logic        loud;
        logic        periodic;
        for (int c = 0; c < NCH; c++)
        begin
            smp = samples[c*SMP_W +: SMP_W];
            if (smp > peak_hold[c])
                peak_hold[c] = smp;
            if (smp < trough_hold[c])
                trough_hold[c] = smp;
        end
        // a zero window length behaves as one round
        needed    = (live_cfg.window_rounds == '0) ? 16'd1 : live_cfg.window_rounds;
        rounds_in = rounds_in + 16'd1;
        // a shrink mid-window closes as soon as the count reaches or passes it
        if (rounds_in != '0 && rounds_in < needed)
            return 1'b0;

        if (cooldown_now != '0)
            cooldown_now = cooldown_now - 8'd1;
        clock_ms = clock_ms + 32'(live_cfg.window_ms);
        if (windows_idle != WINDOW_COUNT_MAX)
            windows_idle = windows_idle + 8'd1;

        // strict compare keeps ties on the earlier channel
        peak = '0;
        dir  = '0;
        for (int c = 0; c < NCH; c++)
        begin
            span = (peak_hold[c] >= trough_hold[c]) ? peak_hold[c] - trough_hold[c] : '0;
            if (c == 0 || span > peak)
            begin
                peak = span;
                dir  = 2'(c);
            end
        end

        loud     = (peak > live_cfg.loud_threshold) && (cooldown_now == '0);
        periodic = (windows_idle >= live_cfg.periodic_windows);

        rep.peak     = peak;
        rep.dir      = dir;
        rep.pct      = 7'((32'(peak) * 32'(PCT_SCALE)) / 32'(FULL_SCALE));
        rep.alert    = loud;
        rep.periodic = periodic;
        rep.evnum    = '0;
        if (loud || periodic)
        begin
            rep.evnum = event_seq;
            event_seq = event_seq + 16'd1;
            if (loud)
                cooldown_now = live_cfg.cooldown_windows;
            windows_idle = '0;
        end
        rep.ms   = clock_ms;
        rep.cool = cooldown_now;
        open_window();
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // Source side: present queued rounds, fold every accepted transaction
    // into the tracker, and insert random idle bursts between rounds.
    always @(posedge clk)
    begin : source_side
        window_report_t rep;
        bit             closes;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                closes = tally_round(s_tdata[NCH*SMP_W-1:0], rep);
                if (closes)
                    window_q.push_back(rep);
            end
            // hold the current round until it is taken
            if (!s_tvalid || s_tready)
            begin
                if (src_gap != 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (round_q.size() != 0 && !calm && src_rate != 0
                         && $urandom_range(1, src_rate) == 1)
                begin
                    src_gap = $urandom_range(0, 10);
                    s_tvalid <= 1'b0;
                end
                else if (round_q.size() != 0)
                begin
                    s_tdata  <= {{(IN_W - NCH*SMP_W){1'b0}}, round_q.pop_front()};
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Sink side: check every result transaction against the oldest owed
    // window, and stall the master side in random bursts.
    always @(posedge clk)
    begin : sink_side
        window_report_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_gap = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (window_q.size() == 0)
                    flag_mismatch("unexpected result", m_tdata[63:0], '0);
                else
                begin
                    want = window_q.pop_front();
                    // fields from bit 0: peak 12, dir 2, pct 7, alert, periodic,
                    // event number 16, time 32, cooldown 8
                    if (m_tdata[11:0] !== want.peak)
                        flag_mismatch("peak_level", 64'(m_tdata[11:0]), 64'(want.peak));
                    if (m_tdata[13:12] !== want.dir)
                        flag_mismatch("direction", 64'(m_tdata[13:12]), 64'(want.dir));
                    if (m_tdata[20:14] !== want.pct)
                        flag_mismatch("intensity", 64'(m_tdata[20:14]), 64'(want.pct));
                    if (m_tdata[21] !== want.alert)
                        flag_mismatch("high_alert", 64'(m_tdata[21]), 64'(want.alert));
                    if (m_tdata[22] !== want.periodic)
                        flag_mismatch("periodic_event", 64'(m_tdata[22]),
                                      64'(want.periodic));
                    if (m_tdata[38:23] !== want.evnum)
                        flag_mismatch("event_number", 64'(m_tdata[38:23]), 64'(want.evnum));
                    if (m_tdata[70:39] !== want.ms)
                        flag_mismatch("time_ms", 64'(m_tdata[70:39]), 64'(want.ms));
                    if (m_tdata[78:71] !== want.cool)
                        flag_mismatch("cooldown_left", 64'(m_tdata[78:71]), 64'(want.cool));
                end
            end
            if (sink_gap != 0)
            begin
                sink_gap--;
                m_tready <= 1'b0;
            end
            else if (!calm && sink_rate != 0 && $urandom_range(1, sink_rate) == 1)
            begin
                sink_gap = $urandom_range(0, 10);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog: end the run when no transaction or register write happens
    // for too long.
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            stall_cycles <= 0;
        else if (stall_cycles == STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Write the registers selected in which, one per cycle, and track them.
    task automatic program_regs(input cfg_t want, input logic [4:0] which);
        logic [CFG_DATA_BITS-1:0] value;
        for (int i = 0; i < 5; i++)
        begin
            if (which[i])
            begin
                case (CFG_INDEX_BITS'(i))
                    REG_WINDOW_ROUNDS:
                    begin
                        value = want.window_rounds;
                        live_cfg.window_rounds = want.window_rounds;
                    end
                    REG_LOUD_THRESHOLD:
                    begin
                        value = 16'(want.loud_threshold);
                        live_cfg.loud_threshold = want.loud_threshold;
                    end
                    REG_COOLDOWN_WINDOWS:
                    begin
                        value = 16'(want.cooldown_windows);
                        live_cfg.cooldown_windows = want.cooldown_windows;
                    end
                    REG_PERIODIC_WINDOWS:
                    begin
                        value = 16'(want.periodic_windows);
                        live_cfg.periodic_windows = want.periodic_windows;
                    end
                    REG_WINDOW_MS:
                    begin
                        value = want.window_ms;
                        live_cfg.window_ms = want.window_ms;
                    end
                    default:
                        value = '0;
                endcase
                @(posedge clk);
                cfg_we    <= 1'b1;
                cfg_index <= CFG_INDEX_BITS'(i);
                cfg_data  <= value;
            end
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Queue random rounds. Every few rounds the per-channel base and swing are
    // redrawn, sometimes with channels tied together; single samples are
    // occasionally forced to the rails.
    task automatic queue_rounds(input int count);
        int          base [NCH];
        int          amp [NCH];
        int          tie;
        logic [11:0] smp [NCH];
        for (int i = 0; i < count; i++)
        begin
            if (i == 0 || $urandom_range(0, 7) == 0)
            begin
                for (int c = 0; c < NCH; c++)
                begin
                    case ($urandom_range(0, 3))
                        0: amp[c] = 0;
                        1: amp[c] = $urandom_range(1, 64);
                        2: amp[c] = $urandom_range(65, 2500);
                        default: amp[c] = 4095;
                    endcase
                    base[c] = $urandom_range(0, 4095 - amp[c]);
                end
                tie = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
            end
            for (int c = 0; c < NCH; c++)
            begin
                smp[c] = 12'(base[c] + $urandom_range(0, amp[c]));
                if ($urandom_range(0, 19) == 0)
                    smp[c] = $urandom_range(0, 1) ? FULL_SCALE : '0;
            end
            if (tie >= 1)
                smp[1] = smp[0];
            if (tie == 2)
                smp[2] = smp[0];
            round_q.push_back({smp[2], smp[1], smp[0]});
        end
    endtask

    // Wait until every round is sent and every owed result is taken, then let
    // the pipeline empty before touching the registers.
    task automatic drain();
        while (round_q.size() != 0 || s_tvalid || window_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin : stimulus
        cfg_t pick;
        live_cfg = '{window_rounds:    RST_WINDOW_ROUNDS,
                     loud_threshold:   RST_LOUD_THRESHOLD,
                     cooldown_windows: RST_COOLDOWN_WINDOWS,
                     periodic_windows: RST_PERIODIC_WINDOWS,
                     window_ms:        RST_WINDOW_MS};
        open_window();
        windows_idle = '0;
        cooldown_now = '0;
        event_seq    = FIRST_EVENT_NUMBER;
        clock_ms     = '0;
        calm         = 1'b0;
        src_rate     = 3;
        sink_rate    = 3;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Opening: quiet rounds under reset settings, then shrink the window
        // below the rounds already seen; the other registers keep reset values.
        for (int i = 0; i < OPEN_QUIET; i++)
            round_q.push_back({12'(OPENING[i][2]), 12'(OPENING[i][1]), 12'(OPENING[i][0])});
        drain();
        pick = live_cfg;
        pick.window_rounds = 16'd4;
        program_regs(pick, 5'b00001);
        for (int i = OPEN_QUIET; i < OPEN_TOTAL; i++)
            round_q.push_back({12'(OPENING[i][2]), 12'(OPENING[i][1]), 12'(OPENING[i][0])});
        drain();

        // Threshold zero with the longest cooldown and periodic limits: alerts
        // and periodic events meet after 255 windows.
        pick = '{window_rounds: 16'd2, loud_threshold: 12'd0, cooldown_windows: 8'd255,
                 periodic_windows: 8'd255, window_ms: 16'd0};
        program_regs(pick, 5'b11111);
        src_rate  = 4;
        sink_rate = 4;
        queue_rounds(530);
        drain();

        // Random settings; phases stop at random points inside a window, so the
        // next setting often lands mid-window.
        for (int phase = 0; phase < 8; phase++)
        begin
            case ($urandom_range(0, 9))
                0: pick.window_rounds = 16'd0;
                1, 2, 3, 4, 5: pick.window_rounds = 16'($urandom_range(1, 8));
                6, 7, 8: pick.window_rounds = 16'($urandom_range(9, 40));
                default: pick.window_rounds = 16'($urandom_range(41, 120));
            endcase
            case ($urandom_range(0, 3))
                0: pick.loud_threshold = 12'd0;
                1: pick.loud_threshold = FULL_SCALE;
                2: pick.loud_threshold = 12'($urandom_range(0, 4095));
                default: pick.loud_threshold = 12'($urandom_range(500, 2500));
            endcase
            case ($urandom_range(0, 3))
                0: pick.cooldown_windows = 8'd0;
                1: pick.cooldown_windows = 8'd255;
                2: pick.cooldown_windows = 8'($urandom_range(0, 5));
                default: pick.cooldown_windows = 8'($urandom_range(0, 20));
            endcase
            case ($urandom_range(0, 3))
                0: pick.periodic_windows = 8'd0;
                1: pick.periodic_windows = 8'($urandom_range(1, 6));
                2: pick.periodic_windows = 8'($urandom_range(1, 30));
                default: pick.periodic_windows = 8'd255;
            endcase
            case ($urandom_range(0, 2))
                0: pick.window_ms = 16'd0;
                1: pick.window_ms = 16'hFFFF;
                default: pick.window_ms = 16'($urandom_range(0, 65535));
            endcase
            program_regs(pick, 5'($urandom_range(1, 31)));
            src_rate  = $urandom_range(0, 2) * 5;
            sink_rate = $urandom_range(0, 2) * 5;
            queue_rounds($urandom_range(70, 110));
            drain();
            if (phase == 3)
            begin
                // longest window, left open for the next setting to cut short
                pick.window_rounds = 16'hFFFF;
                program_regs(pick, 5'b00001);
                queue_rounds(9);
                drain();
            end
        end

        // Last part, no idling: every round closes a window and fires a
        // periodic event.
        calm = 1'b1;
        pick = '{window_rounds: 16'd0, loud_threshold: FULL_SCALE, cooldown_windows: 8'd0,
                 periodic_windows: 8'd0, window_ms: 16'hFFFF};
        program_regs(pick, 5'b11111);
        queue_rounds(60);
        drain();

        if (mismatches == 0 && window_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
